[rtl/core/kcl_pkg.sv]
// Package for the keypad code lock: key codes, event codes, phase type,
// configuration register indexes and the result beat type.
// No dependencies.
package kcl_pkg;

	localparam logic [7:0] KEY_NONE = 8'h00;
	localparam logic [7:0] KEY_HASH = 8'h23;
	localparam logic [7:0] KEY_STAR = 8'h2A;
	localparam logic [7:0] KEY_A    = 8'h41;
	localparam logic [7:0] KEY_B    = 8'h42;
	localparam logic [7:0] KEY_C    = 8'h43;
	localparam logic [7:0] KEY_D    = 8'h44;

	localparam logic [1:0] REG_CODE_VALUE  = 2'd0;
	localparam logic [1:0] REG_CODE_LENGTH = 2'd1;
	localparam logic [1:0] REG_ATTEMPT_LIM = 2'd2;
	localparam logic [1:0] REG_CRED_READY  = 2'd3;

	localparam logic [3:0] MAX_WRONG = 4'd15;

	typedef enum logic [3:0] {
		EV_IGNORED  = 4'd0,
		EV_STARTED  = 4'd1,
		EV_ADDED    = 4'd2,
		EV_ERASED   = 4'd3,
		EV_ACCEPTED = 4'd4,
		EV_WRONG    = 4'd5,
		EV_LOCKED   = 4'd6,
		EV_FACE     = 4'd7,
		EV_FINGER   = 4'd8,
		EV_SESSION  = 4'd9,
		EV_NO_LINK  = 4'd10
	} event_t;

	typedef enum logic {
		PH_IDLE  = 1'b0,
		PH_ENTER = 1'b1
	} phase_t;

	typedef struct packed {
		event_t     ev;
		logic [1:0] cursor;
		logic [3:0] attempt;
		logic [3:0] left;
		logic       beep;
	} result_t;

endpackage

[rtl/core/keypad_code_lock.sv]
// Keypad code lock: one result beat for every input beat.
// Depends on kcl_pkg for key codes, event codes and the result type.
//
// Every accepted input beat is decoded against the lock state combinationally and
// produces exactly one result beat; a new input beat can be taken in every cycle
// in which in_stall is low. The result sits in an output register backed by one skid
// register, so input keeps flowing for one beat while the output is stalled; in_stall
// rises only when both hold a result. Configuration must be written through
// cfg_wen/cfg_addr/cfg_wdata only while idle; the block does not enforce this.
module keypad_code_lock
	import kcl_pkg::*;
#(
	parameter int ENTRY_LENGTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_addr,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [7:0]  key_code,
	input  logic        link_up,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  event_res,
	output logic [1:0]  cursor,
	output logic [3:0]  attempt_number,
	output logic [3:0]  tries_left,
	output logic        beep
);

	localparam int CNT_W = $clog2(ENTRY_LENGTH + 1);
	localparam logic [3:0] ENTRY_MAX = 4'(ENTRY_LENGTH);

	// Configuration registers
	logic [31:0] code_value_q;
	logic [2:0]  code_length_q;
	logic [3:0]  attempt_limit_q;
	logic        cred_ready_q;

	// Lock state
	phase_t           phase_q, phase_d;
	logic [7:0]       keys_q [ENTRY_LENGTH];
	logic [7:0]       keys_d [ENTRY_LENGTH];
	logic [CNT_W-1:0] count_q, count_d;
	logic [3:0]       wrong_q, wrong_d;
	logic             accepted_q, accepted_d;
	logic             locked_q, locked_d;

	// Output register and skid register
	result_t out_q, skid_q, res;
	logic    out_valid_q, skid_valid_q;
	logic    in_acc, out_fire;

	logic [3:0]  count_x;
	logic [3:0]  wrong_inc;
	logic [63:0] code_x;
	logic        match;

	assign in_stall = skid_valid_q;
	assign in_acc   = in_valid && !in_stall;
	assign out_fire = out_valid_q && !out_stall;

	assign count_x   = 4'(count_q);
	assign wrong_inc = (wrong_q == MAX_WRONG) ? MAX_WRONG : wrong_q + 4'd1;
	assign code_x    = {32'b0, code_value_q};

	// Code bytes past the fourth are zero, so longer codes never match.
	always_comb begin
		match = (count_x == {1'b0, code_length_q});
		for (int i = 0; i < ENTRY_LENGTH; i++) begin
			if ((4'(i) < count_x) && (keys_q[i] != code_x[8*i +: 8])) begin
				match = 1'b0;
			end
		end
	end

	always_comb begin
		phase_d    = phase_q;
		keys_d     = keys_q;
		count_d    = count_q;
		wrong_d    = wrong_q;
		accepted_d = accepted_q;
		locked_d   = locked_q;
		res.ev      = EV_IGNORED;
		res.cursor  = 2'd0;
		res.attempt = wrong_inc;
		res.left    = 4'd0;
		res.beep    = 1'b0;

		if (action) begin
			phase_d    = PH_IDLE;
			for (int i = 0; i < ENTRY_LENGTH; i++) keys_d[i] = 8'd0;
			count_d    = '0;
			wrong_d    = 4'd0;
			accepted_d = 1'b0;
			locked_d   = 1'b0;
			res.ev      = EV_SESSION;
			res.attempt = 4'd1;
		end else if (cred_ready_q && key_code != KEY_NONE && !accepted_q && !locked_q) begin
			if (phase_q != PH_ENTER) begin
				case (key_code)
					KEY_HASH, KEY_STAR, KEY_A, KEY_B: res.ev = EV_IGNORED;
					KEY_D: res.ev = link_up ? EV_FACE : EV_NO_LINK;
					KEY_C: res.ev = EV_FINGER;
					default: begin
						for (int i = 0; i < ENTRY_LENGTH; i++) keys_d[i] = 8'd0;
						keys_d[0] = key_code;
						count_d   = CNT_W'(1);
						phase_d   = PH_ENTER;
						res.ev    = EV_STARTED;
						res.beep  = 1'b1;
					end
				endcase
			end else begin
				res.beep = 1'b1;
				case (key_code)
					KEY_HASH: begin
						if (count_x != 4'd0) begin
							phase_d = PH_IDLE;
							for (int i = 0; i < ENTRY_LENGTH; i++) keys_d[i] = 8'd0;
							count_d = '0;
							if (match) begin
								accepted_d = 1'b1;
								res.ev     = EV_ACCEPTED;
							end else begin
								wrong_d = wrong_inc;
								if (wrong_inc >= attempt_limit_q) begin
									locked_d = 1'b1;
									res.ev   = EV_LOCKED;
								end else begin
									res.ev   = EV_WRONG;
									res.left = attempt_limit_q - wrong_inc;
								end
							end
						end
					end
					KEY_STAR: begin
						if (count_x != 4'd0) begin
							count_d = count_q - CNT_W'(1);
							for (int i = 0; i < ENTRY_LENGTH; i++) begin
								if (4'(i) == count_x - 4'd1) keys_d[i] = 8'd0;
							end
							res.ev     = EV_ERASED;
							res.cursor = 2'(count_x - 4'd1);
						end
					end
					KEY_A, KEY_B, KEY_C, KEY_D: res.ev = EV_IGNORED;
					default: begin
						if (count_x < ENTRY_MAX) begin
							for (int i = 0; i < ENTRY_LENGTH; i++) begin
								if (4'(i) == count_x) keys_d[i] = key_code;
							end
							count_d    = count_q + CNT_W'(1);
							res.ev     = EV_ADDED;
							res.cursor = count_x[1:0];
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_value_q    <= 32'd0;
			code_length_q   <= 3'd4;
			attempt_limit_q <= 4'd3;
			cred_ready_q    <= 1'b0;
		end else if (cfg_wen) begin
			case (cfg_addr)
				REG_CODE_VALUE:  code_value_q    <= cfg_wdata;
				REG_CODE_LENGTH: code_length_q   <= cfg_wdata[2:0];
				REG_ATTEMPT_LIM: attempt_limit_q <= cfg_wdata[3:0];
				REG_CRED_READY:  cred_ready_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			count_q    <= '0;
			wrong_q    <= 4'd0;
			accepted_q <= 1'b0;
			locked_q   <= 1'b0;
			for (int i = 0; i < ENTRY_LENGTH; i++) keys_q[i] <= 8'd0;
		end else if (in_acc) begin
			phase_q    <= phase_d;
			count_q    <= count_d;
			wrong_q    <= wrong_d;
			accepted_q <= accepted_d;
			locked_q   <= locked_d;
			keys_q     <= keys_d;
		end
	end

	// A new beat lands in the output register when it is free or being taken;
	// otherwise it waits in the skid register, which stops further input.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) skid_valid_q <= 1'b0;
		end else if (in_acc) begin
			if (out_valid_q && !out_fire) skid_valid_q <= 1'b1;
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) out_q <= skid_q;
		end else if (in_acc) begin
			if (out_valid_q && !out_fire) skid_q <= res;
			else out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign event_res      = out_q.ev;
	assign cursor         = out_q.cursor;
	assign attempt_number = out_q.attempt;
	assign tries_left     = out_q.left;
	assign beep           = out_q.beep;

endmodule
